// ===== sv/tcw_pkg.sv =====
// Shared constants, command codes and status struct for the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer_core; no dependencies.
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int LAST_BASE = COLUMNS * (ROWS - 1);
    localparam int ADDR_W    = 11;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int CELL_W    = 16;

    localparam logic [7:0]        CH_NL      = 8'd10;
    localparam logic [7:0]        CH_CR      = 8'd13;
    localparam logic [7:0]        CH_BS      = 8'd8;
    localparam logic [7:0]        CH_SP      = 8'h20;
    localparam logic [7:0]        MARK       = 8'hFF;
    localparam logic [7:0]        ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, CH_SP};

    typedef logic [3:0] dp_op_t;

    localparam dp_op_t DP_NOP    = 4'd0;
    localparam dp_op_t DP_LATCH  = 4'd1;
    localparam dp_op_t DP_CLEAR  = 4'd2;
    localparam dp_op_t DP_PUT    = 4'd3;
    localparam dp_op_t DP_FILL   = 4'd4;
    localparam dp_op_t DP_NEWROW = 4'd5;
    localparam dp_op_t DP_CR     = 4'd6;
    localparam dp_op_t DP_READ   = 4'd7;
    localparam dp_op_t DP_COPY   = 4'd8;
    localparam dp_op_t DP_BLANK  = 4'd9;
    localparam dp_op_t DP_BSW    = 4'd10;

    typedef struct packed {
        logic is_read;
        logic is_nl;
        logic is_cr;
        logic is_bs;
        logic pos_zero;
        logic col_lt_last;
        logic col_last;
        logic row_last;
        logic mark_prev;
        logic copy_last;
        logic sweep_last;
    } dp_status_t;

endpackage

// ===== sv/tcw_ctrl.sv =====
// Controller state machine for the text console writer.
// Depends on tcw_pkg; drives datapath commands from datapath status.
module tcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tcw_pkg::dp_status_t status,
    output tcw_pkg::dp_op_t   cmd,
    output logic              busy,
    output logic              done
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_EXEC     = 4'd2;
    localparam logic [3:0] ST_NL       = 4'd3;
    localparam logic [3:0] ST_BS_CHECK = 4'd4;
    localparam logic [3:0] ST_SCROLL   = 4'd5;
    localparam logic [3:0] ST_FLUSH    = 4'd6;
    localparam logic [3:0] ST_BLANK    = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = tcw_pkg::DP_NOP;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd = tcw_pkg::DP_CLEAR;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE, ST_DONE:
            begin
                if (start)
                begin
                    cmd        = tcw_pkg::DP_LATCH;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                if (status.is_read)
                begin
                    cmd        = tcw_pkg::DP_READ;
                    state_next = ST_DONE;
                end
                else if (status.is_nl)
                begin
                    state_next = ST_NL;
                end
                else if (status.is_cr)
                begin
                    cmd        = tcw_pkg::DP_CR;
                    state_next = ST_DONE;
                end
                else if (status.is_bs)
                begin
                    if (status.pos_zero)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd        = tcw_pkg::DP_BSW;
                        state_next = ST_BS_CHECK;
                    end
                end
                else
                begin
                    cmd        = tcw_pkg::DP_PUT;
                    state_next = (status.col_last && status.row_last) ? ST_SCROLL : ST_DONE;
                end
            end
            ST_NL:
            begin
                if (status.col_lt_last)
                begin
                    cmd = tcw_pkg::DP_FILL;
                end
                else
                begin
                    cmd        = tcw_pkg::DP_NEWROW;
                    state_next = status.row_last ? ST_SCROLL : ST_DONE;
                end
            end
            ST_BS_CHECK:
            begin
                if (!status.pos_zero && status.mark_prev)
                begin
                    cmd = tcw_pkg::DP_BSW;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                cmd = tcw_pkg::DP_COPY;
                if (status.copy_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_BLANK;
            end
            ST_BLANK:
            begin
                cmd = tcw_pkg::DP_BLANK;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE) && (state_reg != ST_DONE);
    assign done = (state_reg == ST_DONE);

    a_bs_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BS_CHECK) |-> ($past(cmd) == tcw_pkg::DP_BSW))
        else $error("backspace check without preceding write");

    a_blank_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == tcw_pkg::DP_BLANK && $past(cmd) != tcw_pkg::DP_BLANK)
        |-> ($past(state_reg) == ST_FLUSH))
        else $error("blanking started without finished copy");

endmodule

// ===== sv/tcw_datapath.sv =====
// Datapath for the text console writer: screen memory, cursor, item and sweep registers.
// Depends on tcw_pkg; executes commands from tcw_ctrl.
module tcw_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcw_pkg::dp_op_t             cmd,
    input  logic                        operation,
    input  logic [7:0]                  character,
    input  logic [7:0]                  attribute,
    input  logic [tcw_pkg::ADDR_W-1:0]  cell_index,
    input  logic                        cfg_write,
    input  logic [7:0]                  cfg_data,
    output tcw_pkg::dp_status_t         status,
    output logic [tcw_pkg::ADDR_W-1:0]  cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]  cell_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

    logic [tcw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::ADDR_W-1:0] sweep_reg, sweep_next;
    logic [7:0]                 dflt_attr_reg;
    logic                       cp_pend_reg;
    logic [tcw_pkg::ADDR_W-1:0] cp_addr_reg;
    logic                       op_reg;
    logic [7:0]                 ch_reg;
    logic [7:0]                 attr_reg;
    logic [tcw_pkg::ADDR_W-1:0] idx_reg;
    logic [tcw_pkg::CELL_W-1:0] rd_reg;

    logic [tcw_pkg::ADDR_W-1:0] pos;
    logic                       idx_ok;
    logic                       col_last;
    logic                       row_last;
    logic                       wr_en;
    logic [tcw_pkg::ADDR_W-1:0] wr_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data;
    logic [tcw_pkg::ADDR_W-1:0] rd_addr;
    logic [tcw_pkg::ROW_W-1:0]  row_adv;

    assign pos      = tcw_pkg::ADDR_W'(int'(row_reg) * tcw_pkg::COLUMNS + int'(col_reg));
    assign idx_ok   = idx_reg < tcw_pkg::ADDR_W'(tcw_pkg::CELLS);
    assign col_last = col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    assign row_last = row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    assign row_adv  = row_last ? row_reg : row_reg + 1'b1;

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        sweep_next = sweep_reg;
        wr_en      = cp_pend_reg;
        wr_addr    = cp_addr_reg;
        wr_data    = rd_reg;
        rd_addr    = '0;
        case (cmd)
            tcw_pkg::DP_LATCH:
            begin
                sweep_next = '0;
            end
            tcw_pkg::DP_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = tcw_pkg::RESET_CELL;
                sweep_next = sweep_reg + 1'b1;
            end
            tcw_pkg::DP_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos;
                wr_data    = {attr_reg, ch_reg};
                sweep_next = '0;
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row_adv;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            tcw_pkg::DP_FILL:
            begin
                wr_en    = 1'b1;
                wr_addr  = pos;
                wr_data  = {attr_reg, tcw_pkg::MARK};
                col_next = col_reg + 1'b1;
            end
            tcw_pkg::DP_NEWROW:
            begin
                col_next   = '0;
                row_next   = row_adv;
                sweep_next = '0;
            end
            tcw_pkg::DP_CR:
            begin
                col_next = '0;
            end
            tcw_pkg::DP_READ:
            begin
                rd_addr = idx_ok ? idx_reg : '0;
            end
            tcw_pkg::DP_COPY:
            begin
                rd_addr    = sweep_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                sweep_next = sweep_reg + 1'b1;
            end
            tcw_pkg::DP_BLANK:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = {dflt_attr_reg, tcw_pkg::CH_SP};
                sweep_next = sweep_reg + 1'b1;
                row_next   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                col_next   = '0;
            end
            tcw_pkg::DP_BSW:
            begin
                wr_en   = 1'b1;
                wr_addr = pos - 1'b1;
                wr_data = {attr_reg, tcw_pkg::CH_SP};
                rd_addr = pos - 2'd2;
                if (col_reg == '0)
                begin
                    col_next = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
                    row_next = row_reg - 1'b1;
                end
                else
                begin
                    col_next = col_reg - 1'b1;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            sweep_reg     <= '0;
            dflt_attr_reg <= tcw_pkg::ATTR_RESET;
            cp_pend_reg   <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            sweep_reg   <= sweep_next;
            cp_pend_reg <= (cmd == tcw_pkg::DP_COPY);
            if (cfg_write)
            begin
                dflt_attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg <= sweep_reg;
        if (cmd == tcw_pkg::DP_LATCH)
        begin
            op_reg   <= operation;
            ch_reg   <= character;
            attr_reg <= attribute;
            idx_reg  <= cell_index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign status.is_read     = op_reg;
    assign status.is_nl       = ch_reg == tcw_pkg::CH_NL;
    assign status.is_cr       = ch_reg == tcw_pkg::CH_CR;
    assign status.is_bs       = ch_reg == tcw_pkg::CH_BS;
    assign status.pos_zero    = pos == '0;
    assign status.col_lt_last = col_reg < tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
    assign status.col_last    = col_last;
    assign status.row_last    = row_last;
    assign status.mark_prev   = rd_reg[7:0] == tcw_pkg::MARK;
    assign status.copy_last   = sweep_reg == tcw_pkg::ADDR_W'(tcw_pkg::LAST_BASE - 1);
    assign status.sweep_last  = sweep_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);

    assign cursor_position = pos;
    assign cell_data       = (op_reg && idx_ok) ? rd_reg : '0;

endmodule

// ===== sv/text_console_writer_core.sv =====
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  item in   | start, busy          | operation, character, attribute, cell_index
//  result    | done (one cycle)     | cursor_position, cell_data
//  config    | cfg_write            | cfg_data (default attribute)
//
// Read, carriage return and a put that needs no scroll go from execute to done. Backspace erases
// the cell before the cursor, then further cells while they hold the newline fill mark. Newline
// fills the row with mark cells, then moves to the next row. A scroll copies the screen memory
// one cell per cycle, then blanks the last row. After reset the memory is cleared one cell per cycle, busy high.
// The result is shown in the cycle after the item completes; a new item may start then.
module text_console_writer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        operation,
    input  logic [7:0]                  character,
    input  logic [7:0]                  attribute,
    input  logic [tcw_pkg::ADDR_W-1:0]  cell_index,
    input  logic                        cfg_write,
    input  logic [7:0]                  cfg_data,
    output logic                        done,
    output logic [tcw_pkg::ADDR_W-1:0]  cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]  cell_data
);

    tcw_pkg::dp_op_t     cmd;
    tcw_pkg::dp_status_t status;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tcw_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (operation),
        .character       (character),
        .attribute       (attribute),
        .cell_index      (cell_index),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .status          (status),
        .cursor_position (cursor_position),
        .cell_data       (cell_data)
    );

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cursor_position < tcw_pkg::ADDR_W'(tcw_pkg::CELLS)))
        else $error("cursor outside screen");

    a_put_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !status.is_read) |-> (cell_data == '0))
        else $error("put item returned cell data");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item not worked on");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

endmodule
